/* rtl/window_sum_daily_top_k_defines.svh */
// Assertion macros used by the checker file.
`ifndef WINDOW_SUM_DAILY_TOP_K_DEFINES_SVH
`define WINDOW_SUM_DAILY_TOP_K_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define WSK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define WSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/wsk_pkg.sv */
// ----------------------------------------------------------------------------
// wsk_pkg
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package wsk_pkg;

  localparam int MAX_WINDOW_DEF = 256;
  localparam int MAX_RANKS_DEF  = 64;

  localparam int RAIN_W = 8;
  localparam int DAY_W  = 9;
  localparam int MIN_W  = 11;
  localparam int TOT_W  = 16;
  localparam int RANK_W = 6;
  localparam int WLEN_W = 9;
  localparam int RCNT_W = 7;
  localparam int CFG_W  = 9;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_RESULT_COUNT  = 1'b1;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(5);
  localparam logic [RCNT_W-1:0] RCNT_RESET = RCNT_W'(10);

  typedef struct packed {
    logic accept;      // latch request, issue ring reads
    logic calc;        // update sum, write ring, credit window
    logic dup;         // same-day search and removal
    logic put;         // ordered insert
    logic flush_load;  // load current day best for insertion
    logic pop;         // result taken, shift table up
    logic clear;       // end of run
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_ins;
    logic last;
    logic best_valid;
    logic out_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/wsk_ctrl.sv */
// ----------------------------------------------------------------------------
// wsk_ctrl
// Sequencer: one request through ring update, table insertion and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module wsk_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_fire,
  input  wire                 out_tready,
  input  wsk_pkg::dp_status_t sts,
  output logic                in_tready,
  output logic                out_tvalid,
  output wsk_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CALC  = 6'b000010,
    ST_DUP   = 6'b000100,
    ST_PUT   = 6'b001000,
    ST_FLUSH = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   flushing_r, flushing_nxt;

  always_comb begin
    state_nxt    = state_r;
    flushing_nxt = flushing_r;
    cmd          = '0;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_fire;
        if (in_fire) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        if (sts.need_ins) state_nxt = ST_DUP;
        else if (sts.last) state_nxt = ST_FLUSH;
        else state_nxt = ST_IDLE;
      end
      ST_DUP: begin
        cmd.dup   = 1'b1;
        state_nxt = ST_PUT;
      end
      ST_PUT: begin
        cmd.put = 1'b1;
        if (flushing_r) state_nxt = ST_EMIT;
        else if (sts.last) state_nxt = ST_FLUSH;
        else state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        cmd.flush_load = 1'b1;
        if (sts.best_valid) begin
          flushing_nxt = 1'b1;
          state_nxt    = ST_DUP;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.pop = 1'b1;
          if (sts.out_last) begin
            cmd.clear    = 1'b1;
            flushing_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      flushing_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      flushing_r <= flushing_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/wsk_dp.sv */
// ----------------------------------------------------------------------------
// wsk_dp
// Datapath: sample ring, running sum, day best and the ranked day table.
// ----------------------------------------------------------------------------
`default_nettype none

module wsk_dp #(
  parameter int MAX_WINDOW = wsk_pkg::MAX_WINDOW_DEF,
  parameter int MAX_RANKS  = wsk_pkg::MAX_RANKS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wsk_pkg::ctrl_cmd_t               cmd,
  input  wire [wsk_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire                              in_tlast,
  input  wire                              cfg_we,
  input  wire                              cfg_addr,
  input  wire [wsk_pkg::CFG_W-1:0]         cfg_wdata,
  output wsk_pkg::dp_status_t              sts,
  output logic [wsk_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W = $clog2(MAX_RANKS + 1);
  localparam int SUM_W = wsk_pkg::RAIN_W + LEN_W;
  localparam int DW    = wsk_pkg::DAY_W;
  localparam int MW    = wsk_pkg::MIN_W;

  // configuration
  logic [wsk_pkg::WLEN_W-1:0] wlen_r;
  logic [wsk_pkg::RCNT_W-1:0] rcnt_r;
  logic [LEN_W-1:0]           len;
  logic [CNT_W-1:0]           k, k_new;

  always_comb begin
    if (wlen_r == '0) len = LEN_W'(1);
    else if (32'(wlen_r) > MAX_WINDOW) len = LEN_W'(MAX_WINDOW);
    else len = LEN_W'(wlen_r);
    if (rcnt_r == '0) k = CNT_W'(1);
    else if (32'(rcnt_r) > MAX_RANKS) k = CNT_W'(MAX_RANKS);
    else k = CNT_W'(rcnt_r);
    if (cfg_wdata[wsk_pkg::RCNT_W-1:0] == '0) k_new = CNT_W'(1);
    else if (32'(cfg_wdata[wsk_pkg::RCNT_W-1:0]) > MAX_RANKS) k_new = CNT_W'(MAX_RANKS);
    else k_new = CNT_W'(cfg_wdata[wsk_pkg::RCNT_W-1:0]);
  end

  // ring
  logic [wsk_pkg::RAIN_W-1:0] ring_rain_mem [MAX_WINDOW];
  logic [DW+MW-1:0]           ring_dm_mem   [MAX_WINDOW];
  logic [wsk_pkg::RAIN_W-1:0] old_rain_q;
  logic [DW+MW-1:0]           st_dm_q;

  logic [AW-1:0]    pos_r, old_a, st_a, pos_inc;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [31:0]      old_t;

  logic [wsk_pkg::RAIN_W-1:0] rain_r;
  logic [DW-1:0]              day_r;
  logic [MW-1:0]              min_r;
  logic                       last_r;

  always_comb begin
    old_t = 32'(pos_r) + 32'(MAX_WINDOW) - 32'(len);
    if (old_t >= 32'(MAX_WINDOW)) old_t = old_t - 32'(MAX_WINDOW);
    old_a   = AW'(old_t);
    st_a    = (32'(old_a) == MAX_WINDOW - 1) ? '0 : old_a + AW'(1);
    pos_inc = (32'(pos_r) == MAX_WINDOW - 1) ? '0 : pos_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      old_rain_q <= ring_rain_mem[old_a];
      st_dm_q    <= ring_dm_mem[st_a];
      rain_r     <= in_tdata[7:0];
      day_r      <= in_tdata[16:8];
      min_r      <= in_tdata[27:17];
      last_r     <= in_tlast;
    end
    if (cmd.calc) begin
      ring_rain_mem[pos_r] <= rain_r;
      ring_dm_mem[pos_r]   <= {day_r, min_r};
    end
  end

  logic          full_b, credit;
  logic [DW-1:0] cr_day;
  logic [MW-1:0] cr_min;

  always_comb begin
    full_b   = fill_r >= len;
    fill_nxt = full_b ? len : fill_r + LEN_W'(1);
    sum_nxt  = sum_r - (full_b ? SUM_W'(old_rain_q) : '0) + SUM_W'(rain_r);
    credit   = fill_nxt >= len;
    // a one-sample window starts at the sample just taken
    cr_day   = (len == LEN_W'(1)) ? day_r : st_dm_q[DW+MW-1:MW];
    cr_min   = (len == LEN_W'(1)) ? min_r : st_dm_q[MW-1:0];
  end

  // day best and pending insertion
  logic [SUM_W-1:0] best_s_r, ins_s_r;
  logic [DW-1:0]    best_d_r, ins_d_r;
  logic [MW-1:0]    best_m_r, ins_m_r;
  logic             best_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_v_r <= 1'b0;
    end else if (cmd.clear) begin
      best_v_r <= 1'b0;
    end else if (cmd.calc && credit) begin
      best_v_r <= 1'b1;
    end
    if (cmd.calc && credit) begin
      if (best_v_r && cr_day == best_d_r) begin
        if (sum_nxt > best_s_r) begin
          best_s_r <= sum_nxt;
          best_m_r <= cr_min;
        end
      end else begin
        ins_s_r  <= best_s_r;
        ins_d_r  <= best_d_r;
        ins_m_r  <= best_m_r;
        best_s_r <= sum_nxt;
        best_d_r <= cr_day;
        best_m_r <= cr_min;
      end
    end
    if (cmd.flush_load) begin
      ins_s_r <= best_s_r;
      ins_d_r <= best_d_r;
      ins_m_r <= best_m_r;
    end
  end

  // ranked table, one register per entry, shifted in place
  logic [SUM_W-1:0] ts_r [MAX_RANKS];
  logic [DW-1:0]    td_r [MAX_RANKS];
  logic [MW-1:0]    tm_r [MAX_RANKS];
  logic [SUM_W-1:0] ts_nxt [MAX_RANKS];
  logic [DW-1:0]    td_nxt [MAX_RANKS];
  logic [MW-1:0]    tm_nxt [MAX_RANKS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic [MAX_RANKS-1:0] vld, above, match, pre, gt;
  logic [wsk_pkg::RANK_W-1:0] rank_r;

  function automatic logic ranks_above(input logic [SUM_W-1:0] s, input logic [DW-1:0] d,
                                       input logic [MW-1:0] m, input logic [SUM_W-1:0] es,
                                       input logic [DW-1:0] ed, input logic [MW-1:0] em);
    if (s != es) return s > es;
    if (d != ed) return d < ed;
    return m < em;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_RANKS; i++) begin
      vld[i]   = 32'(i) < 32'(cnt_r);
      above[i] = ranks_above(ins_s_r, ins_d_r, ins_m_r, ts_r[i], td_r[i], tm_r[i]);
      match[i] = vld[i] && (td_r[i] == ins_d_r);
      gt[i]    = vld[i] && !above[i];
    end
    pre[0] = match[0];
    for (int i = 1; i < MAX_RANKS; i++) pre[i] = pre[i-1] | match[i];

    ts_nxt   = ts_r;
    td_nxt   = td_r;
    tm_nxt   = tm_r;
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;

    if (cmd.dup) begin
      drop_nxt = |(match & ~above);
      if ((|match) && !(|(match & ~above))) begin
        // remove the older entry of the same day
        for (int i = 0; i < MAX_RANKS - 1; i++) begin
          if (pre[i]) begin
            ts_nxt[i] = ts_r[i+1];
            td_nxt[i] = td_r[i+1];
            tm_nxt[i] = tm_r[i+1];
          end
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end

    if (cmd.put && !drop_r && !(cnt_r == k && &(gt | ~vld))) begin
      if (!gt[0]) begin
        ts_nxt[0] = ins_s_r;
        td_nxt[0] = ins_d_r;
        tm_nxt[0] = ins_m_r;
      end
      for (int i = 1; i < MAX_RANKS; i++) begin
        if (!gt[i]) begin
          ts_nxt[i] = gt[i-1] ? ins_s_r : ts_r[i-1];
          td_nxt[i] = gt[i-1] ? ins_d_r : td_r[i-1];
          tm_nxt[i] = gt[i-1] ? ins_m_r : tm_r[i-1];
        end
      end
      if (cnt_r < k) cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (cmd.pop) begin
      for (int i = 0; i < MAX_RANKS - 1; i++) begin
        ts_nxt[i] = ts_r[i+1];
        td_nxt[i] = td_r[i+1];
        tm_nxt[i] = tm_r[i+1];
      end
      if (cnt_r != '0) cnt_nxt = cnt_r - CNT_W'(1);
    end

    if (cfg_we && cfg_addr == wsk_pkg::REG_RESULT_COUNT && cnt_r > k_new) cnt_nxt = k_new;
    if (cmd.clear) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    ts_r <= ts_nxt;
    td_r <= td_nxt;
    tm_r <= tm_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
      rank_r <= '0;
      wlen_r <= wsk_pkg::WLEN_RESET;
      rcnt_r <= wsk_pkg::RCNT_RESET;
      sum_r  <= '0;
      fill_r <= '0;
      pos_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
      if (cmd.clear) rank_r <= '0;
      else if (cmd.pop) rank_r <= rank_r + wsk_pkg::RANK_W'(1);
      if (cmd.calc) begin
        sum_r  <= sum_nxt;
        fill_r <= fill_nxt;
        pos_r  <= pos_inc;
      end
      if (cfg_we && cfg_addr == wsk_pkg::REG_WINDOW_LENGTH) begin
        wlen_r <= cfg_wdata[wsk_pkg::WLEN_W-1:0];
        sum_r  <= '0;
        fill_r <= '0;
      end
      if (cfg_we && cfg_addr == wsk_pkg::REG_RESULT_COUNT)
        rcnt_r <= cfg_wdata[wsk_pkg::RCNT_W-1:0];
      if (cmd.clear) begin
        sum_r  <= '0;
        fill_r <= '0;
        pos_r  <= '0;
      end
    end
  end

  // need_ins is only looked at in the update cycle
  always_comb begin
    sts.need_ins   = credit && best_v_r && (cr_day != best_d_r);
    sts.last       = last_r;
    sts.best_valid = best_v_r;
    sts.out_last   = cnt_r <= CNT_W'(1);
    out_tuser      = cnt_r == '0;
    out_tlast      = sts.out_last;
    if (cnt_r == '0) out_tdata = '0;
    else out_tdata = {{(wsk_pkg::OUT_TDATA_W - 42){1'b0}}, tm_r[0], td_r[0],
                      wsk_pkg::TOT_W'(ts_r[0]), rank_r};
  end

endmodule

`default_nettype wire

/* rtl/window_sum_daily_top_k.sv */
// ----------------------------------------------------------------------------
// window_sum_daily_top_k
// Sliding-window rain sum with a per-day ranking of the best windows.
// ----------------------------------------------------------------------------
// One sample is taken at a time: accept with ring read, then sum update and
// ring write; a day change adds the same-day search and the ordered insert
// into the ranking registers. The sample ring memories are read at accept,
// before they are written in the update step. On the last sample the current
// day best is inserted (load, same-day search and ordered insert, or only the
// load when no window was credited) and then one result per ranked day is
// offered, at one per cycle while out_tready is high, or a single empty result
// when no full window existed. No clearing pass follows reset.
`default_nettype none

module window_sum_daily_top_k #(
  parameter int MAX_WINDOW = wsk_pkg::MAX_WINDOW_DEF,
  parameter int MAX_RANKS  = wsk_pkg::MAX_RANKS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // rain_value[7:0], day_of_year[16:8], minute_of_day[27:17], zero pad
  input  wire [wsk_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire                             in_tlast,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // rank[5:0], window_total[21:6], start_day[30:22], start_minute[41:31], pad
  output logic [wsk_pkg::OUT_TDATA_W-1:0] out_tdata,
  // empty_res
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  wire                             cfg_we,
  input  wire                             cfg_addr,
  input  wire [wsk_pkg::CFG_W-1:0]        cfg_wdata
);

  wsk_pkg::ctrl_cmd_t  cmd;
  wsk_pkg::dp_status_t sts;

  wsk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_tvalid && in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  wsk_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_RANKS  (MAX_RANKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

/* rtl/window_sum_daily_top_k_checker.sv */
// ----------------------------------------------------------------------------
// window_sum_daily_top_k_checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "window_sum_daily_top_k_defines.svh"

module window_sum_daily_top_k_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [47:0] out_tdata,
  input wire        out_tuser,
  input wire        out_tlast
);

  `WSK_ASSERT_NOW(a_no_overlap, in_tready, !out_tvalid, "input taken while results pending")
  `WSK_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request not held")
  `WSK_ASSERT_NOW(a_empty_alone, out_tvalid && out_tuser, out_tlast && out_tdata == 48'd0,
                  "empty result malformed")
  `WSK_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
                   "stalled result dropped")

endmodule

bind window_sum_daily_top_k window_sum_daily_top_k_checker u_chk (.*);

`default_nettype wire
